### rtl/dqr_pkg.sv
package dqr_pkg;

  localparam int unsigned MAX_MESSAGE = 512;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned LABEL_W     = 6;
  localparam int unsigned TAIL_W      = 3;
  localparam int unsigned COUNT_W     = 5;

  // bytes after the echoed byte that completes the question
  localparam logic [COUNT_W-1:0] ANSWER_LEN = 5'd16;
  // bytes still to be echoed once the name ends (QTYPE, QCLASS)
  localparam logic [TAIL_W-1:0]  TAIL_LEN   = 3'd4;
  localparam logic [POS_W-1:0]   HEADER_END = 10'd11;
  localparam logic [POS_W:0]     ANSWER_ROOM = 11'd17;

  localparam logic [1:0] REG_ADDRESS = 2'd0;
  localparam logic [1:0] REG_TTL     = 2'd1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_LABEL  = 3'd2,
    PH_PTR    = 3'd3,
    PH_TAIL   = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } query_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       drop_frame;
  } reply_t;

  // Answer record after the question: C0 0C, type A, class IN, TTL, RDLENGTH 4, address
  function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                             input logic [31:0] ttl,
                                             input logic [31:0] addr);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hC0;
      4'd1:    b = 8'h0C;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h01;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h04;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/dns_query_responder.sv
// A query byte is accepted into the parser and its response byte is presented on
// reply the next cycle; one query byte per cycle sustained while reply_ready is high.
// The byte that completes the question is followed by a 16-byte answer burst
// from the same reply register, so that byte holds query_ready low until the last answer byte is taken.
// Reset (rst, synchronous): parser to header phase at position 0, reply empty,
// answer_address 0, answer_ttl 60.
module dns_query_responder (
  input  logic             clk,
  input  logic             rst,
  input  logic             query_valid,
  output logic             query_ready,
  input  dqr_pkg::query_t  query,
  output logic             reply_valid,
  input  logic             reply_ready,
  output dqr_pkg::reply_t  reply,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] answer_address;
  logic [31:0] answer_ttl;

  dqr_pkg::phase_t               phase, phase_next;
  logic [dqr_pkg::POS_W-1:0]     pos, pos_next;
  logic [dqr_pkg::LABEL_W-1:0]   label_left, label_left_next;
  logic [dqr_pkg::TAIL_W-1:0]    tail_left, tail_left_next;

  logic                          job_valid, job_valid_next;
  logic [7:0]                    job_byte, job_byte_next;
  logic                          job_drop, job_drop_next;
  logic                          job_answer, job_answer_next;
  logic [dqr_pkg::COUNT_W-1:0]   job_count, job_count_next;

  logic job_final;
  logic take;
  logic [dqr_pkg::LABEL_W-1:0] label_dec;
  logic [dqr_pkg::TAIL_W-1:0]  tail_dec;
  logic tail_done;
  logic too_long;
  logic drop;
  logic [7:0] echo;
  logic [3:0] ans_idx;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dqr_pkg::REG_TTL[0]) ? answer_ttl : answer_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= 32'd0;
      answer_ttl     <= 32'd60;
    end else if (psel && penable && pwrite) begin
      case ({1'b0, paddr[2]})
        dqr_pkg::REG_ADDRESS: answer_address <= pwdata;
        dqr_pkg::REG_TTL:     answer_ttl     <= pwdata;
        default: ;
      endcase
    end
  end

  // reply register
  assign job_final = job_drop ||
                     (job_count == (job_answer ? dqr_pkg::ANSWER_LEN : '0));
  assign query_ready = !job_valid || (reply_ready && job_final);
  assign take = query_valid && query_ready;
  assign reply_valid = job_valid;

  assign ans_idx = job_count[3:0] - 4'd1;
  always_comb begin
    reply.out_byte   = (job_count == '0) ? job_byte
                     : dqr_pkg::answer_byte(ans_idx, answer_ttl, answer_address);
    reply.out_last   = job_drop || (job_answer && (job_count == dqr_pkg::ANSWER_LEN));
    reply.drop_frame = job_drop;
  end

  // parser
  assign label_dec = (label_left != '0) ? label_left - 6'd1 : '0;
  assign tail_dec  = (tail_left != '0) ? tail_left - 3'd1 : '0;
  assign tail_done = (phase == dqr_pkg::PH_TAIL) && (tail_left <= 3'd1);
  assign too_long  = ({1'b0, pos} + dqr_pkg::ANSWER_ROOM) >
                     dqr_pkg::MAX_MESSAGE[dqr_pkg::POS_W:0];
  assign drop      = too_long || (query.in_last && !tail_done);

  always_comb begin
    echo = query.in_byte;
    case (pos)
      10'd2:   echo = 8'h84 | {7'd0, query.in_byte[0]};
      10'd7:   echo = 8'h01;
      10'd3, 10'd6, 10'd8, 10'd9, 10'd10, 10'd11: echo = 8'h00;
      default: ;
    endcase
    if (phase != dqr_pkg::PH_HEADER) echo = query.in_byte;
  end

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    label_left_next = label_left;
    tail_left_next  = tail_left;
    job_valid_next  = job_valid;
    job_byte_next   = job_byte;
    job_drop_next   = job_drop;
    job_answer_next = job_answer;
    job_count_next  = job_count;

    if (job_valid && reply_ready) begin
      if (job_final) job_valid_next = 1'b0;
      else           job_count_next = job_count + 5'd1;
    end

    if (take) begin
      if (phase == dqr_pkg::PH_SKIP) begin
        if (query.in_last) begin
          phase_next = dqr_pkg::PH_HEADER;
          pos_next   = '0;
        end
      end else begin
        job_valid_next  = 1'b1;
        job_count_next  = '0;
        job_answer_next = 1'b0;
        if (drop) begin
          job_byte_next   = 8'h00;
          job_drop_next   = 1'b1;
          phase_next      = query.in_last ? dqr_pkg::PH_HEADER : dqr_pkg::PH_SKIP;
          pos_next        = '0;
          label_left_next = '0;
          tail_left_next  = '0;
        end else begin
          job_byte_next = echo;
          job_drop_next = 1'b0;
          pos_next      = pos + 10'd1;
          case (phase)
            dqr_pkg::PH_HEADER: begin
              if (pos >= dqr_pkg::HEADER_END) phase_next = dqr_pkg::PH_NAME;
            end
            dqr_pkg::PH_NAME: begin
              if (query.in_byte == 8'h00) begin
                phase_next     = dqr_pkg::PH_TAIL;
                tail_left_next = dqr_pkg::TAIL_LEN;
              end else if (query.in_byte[7:6] != 2'b00) begin
                phase_next = dqr_pkg::PH_PTR;   // compression pointer ends the name
              end else begin
                label_left_next = query.in_byte[5:0];
                phase_next      = dqr_pkg::PH_LABEL;
              end
            end
            dqr_pkg::PH_LABEL: begin
              label_left_next = label_dec;
              if (label_dec == '0) phase_next = dqr_pkg::PH_NAME;
            end
            dqr_pkg::PH_PTR: begin
              phase_next     = dqr_pkg::PH_TAIL;
              tail_left_next = dqr_pkg::TAIL_LEN;
            end
            default: begin
              tail_left_next = tail_dec;
            end
          endcase
          if (tail_done) begin
            job_answer_next = 1'b1;
            phase_next      = query.in_last ? dqr_pkg::PH_HEADER : dqr_pkg::PH_SKIP;
            pos_next        = '0;
            label_left_next = '0;
            tail_left_next  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dqr_pkg::PH_HEADER;
      pos        <= '0;
      label_left <= '0;
      tail_left  <= '0;
      job_valid  <= 1'b0;
      job_drop   <= 1'b0;
      job_answer <= 1'b0;
      job_count  <= '0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      label_left <= label_left_next;
      tail_left  <= tail_left_next;
      job_valid  <= job_valid_next;
      job_drop   <= job_drop_next;
      job_answer <= job_answer_next;
      job_count  <= job_count_next;
    end
  end

  always_ff @(posedge clk) begin
    job_byte <= job_byte_next;
  end

`ifndef SYNTHESIS
  a_count_only_in_answer: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_answer |-> job_count == '0)
    else $error("reply count advanced outside an answer burst");

  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_drop |-> !job_answer)
    else $error("drop transfer carries an answer burst");

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    phase == dqr_pkg::PH_HEADER |-> pos <= dqr_pkg::HEADER_END)
    else $error("header phase past the fixed header");

  a_tail_range: assert property (@(posedge clk) disable iff (rst)
    tail_left <= dqr_pkg::TAIL_LEN)
    else $error("tail count out of range");
`endif

endmodule
